/* rtl/sot_pkg.sv */
`default_nettype none

package sot_pkg;

	localparam int COORD_WIDTH = 16;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int SUM_W       = PROD_W + 1;
	localparam int SQ_W        = 2 * COORD_WIDTH;
	localparam int WIDE_W      = 2 * SQ_W;
	localparam int DATA_W      = ((8 * COORD_WIDTH + 7) / 8) * 8;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic        [SQ_W-1:0]        sq_t;
	typedef logic        [WIDE_W-1:0]      wide_t;

	typedef enum logic [2:0] {
		REQ_BOX_BOX  = 3'd0,
		REQ_BOX_CIRC = 3'd1,
		REQ_BOX_ELL  = 3'd2,
		REQ_BOX_SEG  = 3'd3,
		REQ_SEG_SEG  = 3'd4,
		REQ_PT_CIRC  = 3'd5,
		REQ_PT_ELL   = 3'd6
	} req_t;

	typedef struct packed {
		logic circ;
		logic ell;
	} pt_res_t;

endpackage

`default_nettype wire

/* rtl/sot_seg.sv */
`default_nettype none

module sot_seg import sot_pkg::*; (
	input  wire logic   clk,
	input  wire logic   en,
	input  wire coord_t ax1,
	input  wire coord_t ay1,
	input  wire coord_t ax2,
	input  wire coord_t ay2,
	input  wire coord_t bx1,
	input  wire coord_t by1,
	input  wire coord_t bx2,
	input  wire coord_t by2,
	output logic        hit
);

	diff_t adx_s1, ady_s1, bdx_s1, bdy_s1, ox_s1, oy_s1;
	prod_t p_den_a_s2, p_den_b_s2, p_nu_a_s2, p_nu_b_s2, p_nv_a_s2, p_nv_b_s2;
	sum_t  den_s3, nu_s3, nv_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			adx_s1 <= DIFF_W'(ax2) - DIFF_W'(ax1);
			ady_s1 <= DIFF_W'(ay2) - DIFF_W'(ay1);
			bdx_s1 <= DIFF_W'(bx2) - DIFF_W'(bx1);
			bdy_s1 <= DIFF_W'(by2) - DIFF_W'(by1);
			ox_s1  <= DIFF_W'(ax1) - DIFF_W'(bx1);
			oy_s1  <= DIFF_W'(ay1) - DIFF_W'(by1);

			p_den_a_s2 <= adx_s1 * bdy_s1;
			p_den_b_s2 <= bdx_s1 * ady_s1;
			p_nu_a_s2  <= bdx_s1 * oy_s1;
			p_nu_b_s2  <= bdy_s1 * ox_s1;
			p_nv_a_s2  <= adx_s1 * oy_s1;
			p_nv_b_s2  <= ady_s1 * ox_s1;

			den_s3 <= SUM_W'(p_den_a_s2) - SUM_W'(p_den_b_s2);
			nu_s3  <= SUM_W'(p_nu_a_s2) - SUM_W'(p_nu_b_s2);
			nv_s3  <= SUM_W'(p_nv_a_s2) - SUM_W'(p_nv_b_s2);
		end
	end

	always_comb begin
		if (den_s3 > 0) begin
			hit = (nu_s3 > 0) && (nu_s3 < den_s3) && (nv_s3 > 0) && (nv_s3 < den_s3);
		end else if (den_s3 < 0) begin
			hit = (nu_s3 < 0) && (nu_s3 > den_s3) && (nv_s3 < 0) && (nv_s3 > den_s3);
		end else begin
			hit = 1'b0;
		end
	end

endmodule

`default_nettype wire

/* rtl/sot_pt.sv */
`default_nettype none

module sot_pt import sot_pkg::*; (
	input  wire logic   clk,
	input  wire logic   en,
	input  wire coord_t px,
	input  wire coord_t py,
	input  wire coord_t cx,
	input  wire coord_t cy,
	input  wire coord_t ea,
	input  wire coord_t eb,
	output pt_res_t     res
);

	diff_t  dx_s1, dy_s1;
	coord_t ea_s1, eb_s1;
	logic   neg_s1, zero_s1;
	sq_t    x2_s2, y2_s2, a2_s2, b2_s2;
	logic   neg_s2, zero_s2;
	prod_t  dx2_w, dy2_w, ea2_w, eb2_w;
	wide_t  xb_s3, ya_s3, ab_s3;
	logic   circ_s3, zero_s3;

	assign dx2_w = dx_s1 * dx_s1;
	assign dy2_w = dy_s1 * dy_s1;
	assign ea2_w = PROD_W'(ea_s1) * PROD_W'(ea_s1);
	assign eb2_w = PROD_W'(eb_s1) * PROD_W'(eb_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= DIFF_W'(cx) - DIFF_W'(px);
			dy_s1   <= DIFF_W'(cy) - DIFF_W'(py);
			ea_s1   <= ea;
			eb_s1   <= eb;
			neg_s1  <= ea[COORD_WIDTH-1];
			zero_s1 <= (ea == '0) || (eb == '0);

			x2_s2   <= dx2_w[SQ_W-1:0];
			y2_s2   <= dy2_w[SQ_W-1:0];
			a2_s2   <= ea2_w[SQ_W-1:0];
			b2_s2   <= eb2_w[SQ_W-1:0];
			neg_s2  <= neg_s1;
			zero_s2 <= zero_s1;

			xb_s3   <= WIDE_W'(x2_s2) * WIDE_W'(b2_s2);
			ya_s3   <= WIDE_W'(y2_s2) * WIDE_W'(a2_s2);
			ab_s3   <= WIDE_W'(a2_s2) * WIDE_W'(b2_s2);
			circ_s3 <= !neg_s2 &&
				(({1'b0, x2_s2} + {1'b0, y2_s2}) <= {1'b0, a2_s2});
			zero_s3 <= zero_s2;
		end
	end

	assign res.circ = circ_s3;
	assign res.ell  = !zero_s3 && (({1'b0, xb_s3} + {1'b0, ya_s3}) <= {1'b0, ab_s3});

endmodule

`default_nettype wire

/* rtl/shape_overlap_tester.sv */
// Shape overlap tester: each transfer on the input stream carries one query (kind in
// s_tuser, eight Q12.4 coordinates in s_tdata) and yields exactly one transfer on the
// output stream whose bit 0 says whether the two shapes collide. The block is a
// four-stage pipeline (differences, products, sums and wide products, compare and
// select), and a new query is taken every cycle; the only thing that holds the
// input back is a stalled output register.
`default_nettype none

module shape_overlap_tester import sot_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2 from the lowest bit up.
	input  wire logic [DATA_W-1:0] s_tdata,
	// req_type.
	input  wire logic [2:0]        s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// hit, then zero fill.
	output logic [7:0]             m_tdata
);

	coord_t l, t, r, b, p, q, s, w, seg0_ey;
	logic   en;
	logic   v_s1, v_s2, v_s3, v_s4;
	req_t   kind_s1, kind_s2, kind_s3;
	logic   bb_s1, bb_s2, bb_s3, hit_s4, hit_c;
	logic    [3:0] seg_hit;
	pt_res_t [3:0] pt_res;

	assign l = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
	assign t = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
	assign r = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
	assign b = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
	assign p = s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
	assign q = s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
	assign s = s_tdata[6*COORD_WIDTH +: COORD_WIDTH];
	assign w = s_tdata[7*COORD_WIDTH +: COORD_WIDTH];

	assign en       = !v_s4 || m_tready;
	assign s_tready = en;
	assign seg0_ey  = (req_t'(s_tuser) == REQ_SEG_SEG) ? b : t;

	sot_seg u_seg0 (.clk, .en, .ax1(l), .ay1(t), .ax2(r), .ay2(seg0_ey),
		.bx1(p), .by1(q), .bx2(s), .by2(w), .hit(seg_hit[0]));
	sot_seg u_seg1 (.clk, .en, .ax1(r), .ay1(t), .ax2(r), .ay2(b),
		.bx1(p), .by1(q), .bx2(s), .by2(w), .hit(seg_hit[1]));
	sot_seg u_seg2 (.clk, .en, .ax1(r), .ay1(b), .ax2(l), .ay2(b),
		.bx1(p), .by1(q), .bx2(s), .by2(w), .hit(seg_hit[2]));
	sot_seg u_seg3 (.clk, .en, .ax1(l), .ay1(b), .ax2(l), .ay2(t),
		.bx1(p), .by1(q), .bx2(s), .by2(w), .hit(seg_hit[3]));

	sot_pt u_pt0 (.clk, .en, .px(l), .py(t), .cx(p), .cy(q), .ea(s), .eb(w), .res(pt_res[0]));
	sot_pt u_pt1 (.clk, .en, .px(r), .py(t), .cx(p), .cy(q), .ea(s), .eb(w), .res(pt_res[1]));
	sot_pt u_pt2 (.clk, .en, .px(l), .py(b), .cx(p), .cy(q), .ea(s), .eb(w), .res(pt_res[2]));
	sot_pt u_pt3 (.clk, .en, .px(r), .py(b), .cx(p), .cy(q), .ea(s), .eb(w), .res(pt_res[3]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= req_t'(s_tuser);
			bb_s1   <= (l < s) && (r > p) && (t > w) && (b < q);
			kind_s2 <= kind_s1;
			bb_s2   <= bb_s1;
			kind_s3 <= kind_s2;
			bb_s3   <= bb_s2;
			hit_s4  <= hit_c;
		end
	end

	always_comb begin
		case (kind_s3)
			REQ_BOX_BOX:  hit_c = bb_s3;
			REQ_BOX_CIRC: hit_c = pt_res[0].circ || pt_res[1].circ ||
			                      pt_res[2].circ || pt_res[3].circ;
			REQ_BOX_ELL:  hit_c = pt_res[0].ell || pt_res[1].ell ||
			                      pt_res[2].ell || pt_res[3].ell;
			REQ_BOX_SEG:  hit_c = |seg_hit;
			REQ_SEG_SEG:  hit_c = seg_hit[0];
			REQ_PT_CIRC:  hit_c = pt_res[0].circ;
			REQ_PT_ELL:   hit_c = pt_res[0].ell;
			default:      hit_c = 1'b0;
		endcase
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {7'b0, hit_s4};

	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not track the output register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or vanished");

	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:1] == 7'b0)
		else $error("result fill bits are not zero");

endmodule

`default_nettype wire

/* tb/sv/shape_overlap_tester_test.sv */
`timescale 1ns / 100ps

module shape_overlap_tester_test;
	import sot_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	// a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2 from the lowest bit up.
	logic [DATA_W-1:0] s_tdata;
	// req_type.
	logic [2:0]        s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	// hit, then zero fill.
	logic [7:0]        m_tdata;

	logic expected_hits[$];
	int   error_count = 0;
	int   idle_cycles = 0;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   recv_hold;
	bit   run_done;

	shape_overlap_tester DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic bit point_in_circle(longint px, longint py, longint cx, longint cy,
			longint r);
		longint dx;
		longint dy;
		dx = cx - px;
		dy = cy - py;
		if (r < 0)
			return 1'b0;
		return dx * dx + dy * dy <= r * r;
	endfunction

	function automatic bit point_in_ellipse(longint px, longint py, longint cx, longint cy,
			longint ea, longint eb);
		logic [127:0] lhs;
		logic [127:0] rhs;
		logic [63:0]  dx2;
		logic [63:0]  dy2;
		logic [63:0]  a2;
		logic [63:0]  b2;
		if (ea == 0 || eb == 0)
			return 1'b0;
		dx2 = (cx - px) * (cx - px);
		dy2 = (cy - py) * (cy - py);
		a2 = ea * ea;
		b2 = eb * eb;
		lhs = 128'(dx2) * 128'(b2) + 128'(dy2) * 128'(a2);
		rhs = 128'(a2) * 128'(b2);
		return lhs <= rhs;
	endfunction

	function automatic bit segments_cross(longint ax1, longint ay1, longint ax2, longint ay2,
			longint bx1, longint by1, longint bx2, longint by2);
		longint den;
		longint nu;
		longint nv;
		den = (ax2 - ax1) * (by2 - by1) - (bx2 - bx1) * (ay2 - ay1);
		nu = (bx2 - bx1) * (ay1 - by1) - (by2 - by1) * (ax1 - bx1);
		nv = (ax2 - ax1) * (ay1 - by1) - (ay2 - ay1) * (ax1 - bx1);
		if (den > 0)
			return nu > 0 && nu < den && nv > 0 && nv < den;
		if (den < 0)
			return nu < 0 && nu > den && nv < 0 && nv > den;
		return 1'b0;
	endfunction

	function automatic bit predict_hit(logic [2:0] kind, coord_t c[8]);
		longint l, t, r, b, p, q, s, w;
		bit hit;
		l = c[0]; t = c[1]; r = c[2]; b = c[3];
		p = c[4]; q = c[5]; s = c[6]; w = c[7];
		hit = 1'b0;
		case (kind)
			REQ_BOX_BOX: hit = l < s && r > p && t > w && b < q;
			REQ_BOX_CIRC: hit = point_in_circle(l, t, p, q, s) || point_in_circle(r, t, p, q, s)
				|| point_in_circle(l, b, p, q, s) || point_in_circle(r, b, p, q, s);
			REQ_BOX_ELL: hit = point_in_ellipse(l, t, p, q, s, w)
				|| point_in_ellipse(r, t, p, q, s, w)
				|| point_in_ellipse(l, b, p, q, s, w)
				|| point_in_ellipse(r, b, p, q, s, w);
			REQ_BOX_SEG: hit = segments_cross(l, t, r, t, p, q, s, w)
				|| segments_cross(r, t, r, b, p, q, s, w)
				|| segments_cross(r, b, l, b, p, q, s, w)
				|| segments_cross(l, b, l, t, p, q, s, w);
			REQ_SEG_SEG: hit = segments_cross(l, t, r, b, p, q, s, w);
			REQ_PT_CIRC: hit = point_in_circle(l, t, p, q, s);
			REQ_PT_ELL: hit = point_in_ellipse(l, t, p, q, s, w);
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	task automatic send_query(logic [2:0] kind, coord_t c[8]);
		logic [DATA_W-1:0] packed_data;
		packed_data = '0;
		for (int i = 0; i < 8; i++)
			packed_data[i*COORD_WIDTH +: COORD_WIDTH] = c[i];
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= packed_data;
		s_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_tready);
		expected_hits.push_back(predict_hit(kind, c));
	endtask

	task automatic end_burst;
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic coord_t rand_coord(int spread);
		case (spread)
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(1024)) - 512);
			default: return coord_t'($signed($urandom_range(64)) - 32);
		endcase
	endfunction

	task automatic wait_drained;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_directed;
		coord_t c[8];
		coord_t ext[4];
		ext = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001};
		c = '{0, 100, 100, 0, 50, 150, 150, 50};
		send_query(REQ_BOX_BOX, c);
		c = '{0, 100, 100, 0, 100, 150, 150, 50};
		send_query(REQ_BOX_BOX, c);
		c = '{0, 10, 10, 0, 12, 12, 5, 0};
		send_query(REQ_BOX_CIRC, c);
		c = '{0, 10, 10, 0, 0, 0, -5, 0};
		send_query(REQ_BOX_CIRC, c);
		c = '{0, 10, 10, 0, 12, 12, 5, 3};
		send_query(REQ_BOX_ELL, c);
		c = '{0, 10, 10, 0, 0, 0, 5, 0};
		send_query(REQ_BOX_ELL, c);
		c = '{0, 10, 10, 0, 0, 0, -5, -5};
		send_query(REQ_BOX_ELL, c);
		c = '{0, 10, 10, 0, 5, -5, 5, 20};
		send_query(REQ_BOX_SEG, c);
		c = '{0, 0, 10, 10, 0, 10, 10, 0};
		send_query(REQ_SEG_SEG, c);
		c = '{0, 0, 10, 10, 1, 0, 11, 10};
		send_query(REQ_SEG_SEG, c);
		c = '{0, 0, 10, 10, 10, 10, 20, 0};
		send_query(REQ_SEG_SEG, c);
		c = '{3, 4, 0, 0, 0, 0, 5, 0};
		send_query(REQ_PT_CIRC, c);
		c = '{3, 4, 0, 0, 0, 0, 4, 0};
		send_query(REQ_PT_CIRC, c);
		c = '{4, 0, 0, 0, 0, 0, 4, 2};
		send_query(REQ_PT_ELL, c);
		c = '{1, 1, 0, 0, 0, 0, 4, 0};
		send_query(REQ_PT_ELL, c);
		c = '{0, 0, 0, 0, 0, 0, 5, 5};
		send_query(3'd7, c);
		for (int k = 0; k < 7; k++) begin
			for (int i = 0; i < 8; i++)
				c[i] = ext[(i + k) % 4];
			send_query(3'(k), c);
		end
		end_burst();
		wait_drained();
	endtask

	task automatic test_random(int count);
		coord_t c[8];
		int spread;
		for (int n = 0; n < count; n++) begin
			spread = $urandom_range(2);
			for (int i = 0; i < 8; i++)
				c[i] = rand_coord(spread);
			if ($urandom_range(3) != 0) begin
				c[6] = coord_t'($urandom_range(300));
				c[7] = coord_t'($urandom_range(300));
			end
			send_query(3'($urandom_range(7)), c);
		end
		end_burst();
	endtask

	task automatic test_backpressure;
		recv_hold = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				recv_hold = 1'b0;
			end
			test_random(30);
		join
		wait_drained();
	endtask

	task automatic test_pause;
		test_random(20);
		wait_drained();
		test_random(20);
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_hits.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					if (m_tdata !== {7'd0, expected_hits[0]})
						report_mismatch($sformatf("hit %0h, expected %0b", m_tdata,
							expected_hits[0]));
					void'(expected_hits.pop_front());
				end
			end
			m_tready <= !recv_hold && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000 && !run_done) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		recv_hold = 1'b0;
		run_done = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(130);
		send_idle_pct = 51;
		test_random(120);
		send_idle_pct = 0;
		recv_stall_pct = 51;
		test_random(120);
		send_idle_pct = 15;
		recv_stall_pct = 15;
		test_random(110);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_backpressure();
		test_pause();
		wait_drained();
		run_done = 1'b1;
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* shape_overlap_tester.f */
rtl/sot_pkg.sv
rtl/sot_seg.sv
rtl/sot_pt.sv
rtl/shape_overlap_tester.sv
tb/sv/shape_overlap_tester_test.sv
